>>> sv/grcd_pkg.sv
// ---------------------------------------------------------------------------
// grcd_pkg: shared definitions for the grid region corner detector
// Field widths, register indexes and the chunk mask function.
// ---------------------------------------------------------------------------
package grcd_pkg;

  localparam int VALUE_W = 64;
  localparam int COUNT_W = 17;
  localparam int GRID_CFG_W = 9;
  localparam int CHUNK_CFG_W = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BYTES = 1'b1;

  localparam logic [GRID_CFG_W-1:0] GRID_SIZE_RESET = 9'd16;
  localparam logic [CHUNK_CFG_W-1:0] CHUNK_BYTES_RESET = 4'd8;

  typedef logic [VALUE_W-1:0] value_t;

  // Builds a mask that keeps the low nbytes bytes of a value.
  function automatic value_t chunk_mask(input logic [CHUNK_CFG_W-1:0] nbytes);
    value_t m;
    m = '0;
    for (int i = 0; i < VALUE_W / 8; i++) begin
      if (i < int'(nbytes)) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/grcd_cell.sv
// ---------------------------------------------------------------------------
// grcd_cell: one stage of the line buffer chain
// Holds one masked cell value and loads either the new value or its neighbor.
// ---------------------------------------------------------------------------
module grcd_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load_here,
  input  grcd_pkg::value_t in_value,
  input  grcd_pkg::value_t prev_value,
  output grcd_pkg::value_t value
);
  import grcd_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= load_here ? in_value : prev_value;
    end
  end

endmodule

>>> sv/grcd_line_chain.sv
// ---------------------------------------------------------------------------
// grcd_line_chain: previous-row line buffer as a chain of cells
// New values enter at a position set by the grid size and leave at the far end.
// ---------------------------------------------------------------------------
module grcd_line_chain #(
  parameter int MAX_GRID = 256
) (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [$clog2(MAX_GRID)-1:0] entry,
  input  grcd_pkg::value_t            in_value,
  output grcd_pkg::value_t            tap
);
  import grcd_pkg::*;

  localparam int IW = $clog2(MAX_GRID);

  value_t chain [MAX_GRID];

  for (genvar j = 0; j < MAX_GRID; j++) begin : g_cell
    if (j == 0) begin : g_head
      grcd_cell u_cell (
        .clk        (clk),
        .shift      (shift),
        .load_here  (entry == IW'(j)),
        .in_value   (in_value),
        .prev_value (in_value),
        .value      (chain[j])
      );
    end else begin : g_body
      grcd_cell u_cell (
        .clk        (clk),
        .shift      (shift),
        .load_here  (entry == IW'(j)),
        .in_value   (in_value),
        .prev_value (chain[j-1]),
        .value      (chain[j])
      );
    end
  end

  assign tap = chain[MAX_GRID-1];

endmodule

>>> sv/grid_region_corner_detector_core.sv
// ---------------------------------------------------------------------------
// grid_region_corner_detector_core: raster-order region corner detector
// Flags cells that differ from the cell above and the cell before them.
// ---------------------------------------------------------------------------
// The block accepts one cell per clock cycle in raster order while results
// are taken, and returns one result per cell from an output register in the
// cycle after acceptance, taking a new request in the same cycle that a waiting
// result is taken, so it sustains one cell per cycle. A cell is a corner when
// it is in the first row or differs from the cell above, and also is in the
// first column or differs from the cell before it. Only the low chunk_bytes
// bytes count. The previous row lives in a chain of MAX_GRID cells that shifts
// once per accepted request; new values enter the chain grid_size cells from
// its end, so the value leaving the end is the one from the same column of the
// previous row. No clearing pass is needed after reset. Writing either
// configuration register starts a new grid, as does the last cell of a grid.
module grid_region_corner_detector_core #(
  parameter int MAX_GRID = 256,
  parameter int MAX_CHUNK_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [grcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [grcd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [grcd_pkg::VALUE_W-1:0]         cell_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 is_corner,
  output logic [grcd_pkg::VALUE_W-1:0]         corner_value,
  output logic [grcd_pkg::COUNT_W-1:0]         corners_so_far,
  output logic                                 last_cell
);
  import grcd_pkg::*;

  localparam int IW = $clog2(MAX_GRID);
  localparam int SW = $clog2(MAX_GRID + 1);

  // Configuration registers.
  logic [GRID_CFG_W-1:0]  grid_cfg;
  logic [CHUNK_CFG_W-1:0] chunk_cfg;

  // Grid position and running count.
  logic [IW-1:0]      row_index;
  logic [IW-1:0]      column_index;
  logic [COUNT_W-1:0] corner_total;
  value_t             previous_cell;

  logic [IW-1:0]      row_index_next;
  logic [IW-1:0]      column_index_next;
  logic [COUNT_W-1:0] corner_total_next;

  logic               in_fire;
  logic [31:0]        size_wide;
  logic [31:0]        bytes_wide;
  logic [SW-1:0]      eff_size;
  logic [SW-1:0]      size_last;
  logic [IW-1:0]      entry;
  value_t             mask;
  value_t             masked;
  value_t             above_value;
  logic               above_diff;
  logic               before_diff;
  logic               corner_now;
  logic               last_now;
  logic               col_last;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Clamp the registers into their working ranges.
  always_comb begin
    size_wide = 32'(grid_cfg);
    if (size_wide < 32'd1) begin
      size_wide = 32'd1;
    end else if (size_wide > 32'(MAX_GRID)) begin
      size_wide = 32'(MAX_GRID);
    end
    bytes_wide = 32'(chunk_cfg);
    if (bytes_wide < 32'd1) begin
      bytes_wide = 32'd1;
    end else if (bytes_wide > 32'(MAX_CHUNK_BYTES)) begin
      bytes_wide = 32'(MAX_CHUNK_BYTES);
    end
  end

  assign eff_size  = SW'(size_wide);
  assign size_last = eff_size - SW'(1);
  assign entry     = IW'(32'(MAX_GRID) - size_wide);
  assign mask      = chunk_mask(CHUNK_CFG_W'(bytes_wide));
  assign masked    = cell_value & mask;

  grcd_line_chain #(
    .MAX_GRID (MAX_GRID)
  ) u_line (
    .clk      (clk),
    .shift    (in_fire),
    .entry    (entry),
    .in_value (masked),
    .tap      (above_value)
  );

  // Stored values are already masked and the mask cannot change inside a grid.
  assign above_diff  = (row_index == '0) || (above_value != masked);
  assign before_diff = (column_index == '0) || (previous_cell != masked);
  assign corner_now  = above_diff && before_diff;
  assign col_last    = SW'(column_index) == size_last;
  assign last_now    = (SW'(row_index) == size_last) && col_last;

  always_comb begin
    corner_total_next = corner_total;
    if (corner_now && corner_total != COUNT_MAX) begin
      corner_total_next = corner_total + COUNT_W'(1);
    end
    row_index_next    = row_index;
    column_index_next = column_index + IW'(1);
    if (last_now) begin
      row_index_next    = '0;
      column_index_next = '0;
    end else if (col_last) begin
      row_index_next    = row_index + IW'(1);
      column_index_next = '0;
    end
  end

  // Control state: configuration, position, count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cfg     <= GRID_SIZE_RESET;
      chunk_cfg    <= CHUNK_BYTES_RESET;
      row_index    <= '0;
      column_index <= '0;
      corner_total <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GRID_SIZE:   grid_cfg  <= GRID_CFG_W'(cfg_data);
          REG_CHUNK_BYTES: chunk_cfg <= CHUNK_CFG_W'(cfg_data);
          default: ;
        endcase
        row_index    <= '0;
        column_index <= '0;
        corner_total <= '0;
      end else if (in_fire) begin
        row_index    <= row_index_next;
        column_index <= column_index_next;
        corner_total <= last_now ? '0 : corner_total_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      previous_cell  <= masked;
      is_corner      <= corner_now;
      corner_value   <= masked;
      corners_so_far <= corner_total_next;
      last_cell      <= last_now;
    end
  end

  // The last cell of a grid always sends the position and count back to zero.
  a_grid_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last_now && !cfg_write) |=>
      (row_index == '0 && column_index == '0 && corner_total == '0))
    else $error("grid did not restart after its last cell");

  // A reported corner always carries a nonzero count.
  a_corner_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_corner) |-> (corners_so_far != '0))
    else $error("corner reported with zero count");

  // A cell that is not a corner and not the last of its grid leaves the running count untouched.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !corner_now && !last_now && !cfg_write) |=>
      (corner_total == $past(corner_total)))
    else $error("count changed on a non-corner cell");

  // An accepted request always yields a pending result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted request produced no result");

endmodule
